// ===== rtl/wufq_pkg.sv =====
package wufq_pkg;

    localparam int NUM_ELEMENTS = 4096;
    localparam int IDX_W  = 12;
    localparam int OFF_W  = 12;
    localparam int SIZE_W = 13;
    localparam int GAP_W  = 13;
    localparam int ALU_W  = 13;

    localparam logic CMD_MERGE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

endpackage

// ===== rtl/wufq_ram.sv =====
module wufq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/wufq_alu.sv =====
module wufq_alu (
    input  wufq_pkg::alu_op_t            op,
    input  logic [wufq_pkg::ALU_W-1:0]   x,
    input  logic [wufq_pkg::ALU_W-1:0]   y,
    output logic [wufq_pkg::ALU_W-1:0]   res
);

    import wufq_pkg::*;

    always_comb
    begin
        case (op)
            ALU_ADD: res = x + y;
            ALU_SUB: res = x - y;
            default: res = x + y;
        endcase
    end

endmodule

// ===== rtl/weighted_union_find_queue_distance.sv =====
// Stacked-column disjoint-set over 4096 elements. After reset the block sweeps all three tables
// with busy high, then takes commands. A find walks the parent chain once to sum offsets, one
// hop at a time, and once more to compress it, so the work per item grows with the hops of a
// and b; a merge of two sets adds size-table steps and a query adds gap steps. Each table has a
// single read port and one shared adder does all sums, so hops and steps run one after another.
// A query gives one result beat on done (same_set, gap) for one cycle, a merge gives none; the
// receiver must take the beat when it comes.
module weighted_union_find_queue_distance (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [wufq_pkg::IDX_W-1:0]   elem_a,
    input  logic [wufq_pkg::IDX_W-1:0]   elem_b,
    output logic                         done,
    output logic                         same_set,
    output logic signed [wufq_pkg::GAP_W-1:0] gap
);

    import wufq_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_P1_ISS = 4'd2;
    localparam logic [3:0] S_P1_CHK = 4'd3;
    localparam logic [3:0] S_P2_ISS = 4'd4;
    localparam logic [3:0] S_P2_CHK = 4'd5;
    localparam logic [3:0] S_GAP1   = 4'd6;
    localparam logic [3:0] S_GAP2   = 4'd7;
    localparam logic [3:0] S_M1     = 4'd8;
    localparam logic [3:0] S_M2     = 4'd9;
    localparam logic [3:0] S_M3     = 4'd10;
    localparam logic [3:0] S_M4     = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic              which_reg, which_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [OFF_W-1:0]  sum_reg, sum_next;
    logic [OFF_W-1:0]  dist_reg, dist_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic [IDX_W-1:0]  ra_reg, ra_next;
    logic [OFF_W-1:0]  oa_reg, oa_next;
    logic [SIZE_W-1:0] szb_reg, szb_next;
    logic              done_reg, done_next;
    logic              same_reg, same_next;
    logic [GAP_W-1:0]  gap_reg, gap_next;

    // parent and offset tables share addressing
    logic              po_we;
    logic [IDX_W-1:0]  po_waddr, po_raddr;
    logic [IDX_W-1:0]  par_wdata, par_rdata;
    logic [OFF_W-1:0]  off_wdata, off_rdata;
    logic              sz_we;
    logic [IDX_W-1:0]  sz_waddr, sz_raddr;
    logic [SIZE_W-1:0] sz_wdata, sz_rdata;

    alu_op_t           alu_op;
    logic [ALU_W-1:0]  alu_x, alu_y, alu_res;
    logic              in_ok;

    wufq_ram #(.WIDTH(IDX_W), .DEPTH(NUM_ELEMENTS)) u_parent (
        .clk(clk), .we(po_we), .waddr(po_waddr), .wdata(par_wdata),
        .raddr(po_raddr), .rdata(par_rdata)
    );

    wufq_ram #(.WIDTH(OFF_W), .DEPTH(NUM_ELEMENTS)) u_offset (
        .clk(clk), .we(po_we), .waddr(po_waddr), .wdata(off_wdata),
        .raddr(po_raddr), .rdata(off_rdata)
    );

    wufq_ram #(.WIDTH(SIZE_W), .DEPTH(NUM_ELEMENTS)) u_size (
        .clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
        .raddr(sz_raddr), .rdata(sz_rdata)
    );

    wufq_alu u_alu (
        .op(alu_op), .x(alu_x), .y(alu_y), .res(alu_res)
    );

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign same_set = same_reg;
    assign gap      = gap_reg;
    assign in_ok    = (32'(elem_a) < NUM_ELEMENTS) && (32'(elem_b) < NUM_ELEMENTS);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        which_next = which_reg;
        cur_next   = cur_reg;
        sum_next   = sum_reg;
        dist_next  = dist_reg;
        root_next  = root_reg;
        ra_next    = ra_reg;
        oa_next    = oa_reg;
        szb_next   = szb_reg;
        done_next  = 1'b0;
        same_next  = same_reg;
        gap_next   = gap_reg;

        po_we     = 1'b0;
        po_waddr  = cur_reg;
        po_raddr  = cur_reg;
        par_wdata = root_reg;
        off_wdata = sum_reg;
        sz_we     = 1'b0;
        sz_waddr  = root_reg;
        sz_raddr  = root_reg;
        sz_wdata  = '0;
        alu_op    = ALU_ADD;
        alu_x     = ALU_W'(sum_reg);
        alu_y     = ALU_W'(off_rdata);

        case (state_reg)
            S_CLEAR:
            begin
                po_we     = 1'b1;
                po_waddr  = clr_reg;
                par_wdata = clr_reg;
                off_wdata = '0;
                sz_we     = 1'b1;
                sz_waddr  = clr_reg;
                sz_wdata  = SIZE_W'(1);
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(NUM_ELEMENTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    a_next     = elem_a;
                    b_next     = elem_b;
                    which_next = 1'b0;
                    cur_next   = elem_a;
                    sum_next   = '0;
                    if (in_ok)
                    begin
                        state_next = S_P1_ISS;
                    end
                    else if (command == CMD_QUERY)
                    begin
                        done_next = 1'b1;
                        same_next = 1'b0;
                        gap_next  = '1;
                    end
                end
            end
            S_P1_ISS:
            begin
                state_next = S_P1_CHK;
            end
            S_P1_CHK:
            begin
                if (par_rdata == cur_reg)
                begin
                    root_next  = cur_reg;
                    dist_next  = sum_reg;
                    cur_next   = which_reg ? b_reg : a_reg;
                    state_next = S_P2_ISS;
                end
                else
                begin
                    sum_next = alu_res[OFF_W-1:0];
                    cur_next = par_rdata;
                    po_raddr = par_rdata;
                end
            end
            S_P2_ISS:
            begin
                state_next = S_P2_CHK;
            end
            S_P2_CHK:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!which_reg)
                    begin
                        ra_next    = root_reg;
                        oa_next    = dist_reg;
                        which_next = 1'b1;
                        cur_next   = b_reg;
                        sum_next   = '0;
                        state_next = S_P1_ISS;
                    end
                    else if (cmd_reg == CMD_QUERY)
                    begin
                        if (ra_reg != root_reg)
                        begin
                            done_next  = 1'b1;
                            same_next  = 1'b0;
                            gap_next   = '1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_GAP1;
                        end
                    end
                    else if (ra_reg == root_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_M1;
                    end
                end
                else
                begin
                    // point at root with the remaining distance, then step up
                    po_we    = 1'b1;
                    alu_op   = ALU_SUB;
                    sum_next = alu_res[OFF_W-1:0];
                    cur_next = par_rdata;
                    po_raddr = par_rdata;
                end
            end
            S_GAP1:
            begin
                alu_op = ALU_SUB;
                if (oa_reg >= dist_reg)
                begin
                    alu_x = ALU_W'(oa_reg);
                    alu_y = ALU_W'(dist_reg);
                end
                else
                begin
                    alu_x = ALU_W'(dist_reg);
                    alu_y = ALU_W'(oa_reg);
                end
                sum_next   = alu_res[OFF_W-1:0];
                state_next = S_GAP2;
            end
            S_GAP2:
            begin
                alu_op     = ALU_SUB;
                alu_x      = ALU_W'(sum_reg);
                alu_y      = ALU_W'(1);
                done_next  = 1'b1;
                same_next  = 1'b1;
                gap_next   = GAP_W'(alu_res);
                state_next = S_IDLE;
            end
            S_M1:
            begin
                sz_raddr   = root_reg;
                state_next = S_M2;
            end
            S_M2:
            begin
                szb_next   = sz_rdata;
                sz_raddr   = ra_reg;
                state_next = S_M3;
            end
            S_M3:
            begin
                alu_x      = ALU_W'(szb_reg);
                alu_y      = ALU_W'(sz_rdata);
                sz_we      = 1'b1;
                sz_waddr   = root_reg;
                sz_wdata   = SIZE_W'(alu_res);
                po_we      = 1'b1;
                po_waddr   = ra_reg;
                par_wdata  = root_reg;
                off_wdata  = szb_reg[OFF_W-1:0];
                state_next = S_M4;
            end
            S_M4:
            begin
                sz_we      = 1'b1;
                sz_waddr   = ra_reg;
                sz_wdata   = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        which_reg <= which_next;
        cur_reg   <= cur_next;
        sum_reg   <= sum_next;
        dist_reg  <= dist_next;
        root_reg  <= root_next;
        ra_reg    <= ra_next;
        oa_reg    <= oa_next;
        szb_reg   <= szb_next;
        same_reg  <= same_next;
        gap_reg   <= gap_next;
    end

endmodule
